// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the nibble Huffman encoder.
// Both forms sample on the rising edge of clk; the first one is off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while rst is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/nhe_pkg.sv =====
// Shared types and constants of the nibble Huffman encoder.
// No dependencies; imported by nibble_huffman_encoder and testbench.
package nhe_pkg;

  localparam int unsigned NUM_CFG_REGS = 5;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CODE_W       = 16;
  localparam int unsigned LEN_W        = 4;
  localparam int unsigned SYM_W        = 4;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned COUNT_W      = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CODES_SYM0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODES_SYM4  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODES_SYM8  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODES_SYM12 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTHS = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              final_byte;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              run_end;
    logic              stream_end;
  } out_word_t;

endpackage

// ===== rtl/nibble_huffman_encoder.sv =====
// Nibble Huffman encoder: top level with its bit-serial packing sequencer.
// Depends on nhe_pkg and assert_macros.svh.
//
// Usage:
// - Input channel in_valid/in_ready/in_word: one source byte per word, low
//   nibble encoded first, then high nibble. final_byte ends the stream.
// - Output channel out_valid/out_ready/out_word: packed bytes, first code bit
//   in bit 7. run_end marks the last word caused by an input word, and
//   stream_end marks the last word of the stream (zero padded).
// - Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data: five 64-bit
//   table registers, always ready; the user must write them only while the
//   encoder is idle, which the block does not enforce.
// - Timing: one shared shift unit moves one code bit per cycle in ST_SHIFT
//   unless an output stall holds it. Code lengths above MAX_CODE_LEN are
//   clamped; a final word flushes pending bits as a zero-padded byte.
//   in_ready is high only between words.
// - A completed byte waits in a holding register until the next one is done
//   or the word ends, so that run_end can be set. An output stall freezes the
//   shift unit at a completed byte when output and holding registers are full.
// - Reset (rst, synchronous) clears the tables, the pending bits and all
//   handshake state.
module nibble_huffman_encoder
  import nhe_pkg::*;
#(
  parameter int unsigned MAX_CODE_LEN = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SHIFT,
    ST_END
  } state_t;

  state_t state;

  logic [CFG_DATA_W-1:0] codes [4];
  logic [CFG_DATA_W-1:0] code_lengths;

  logic [BYTE_W-1:0] data;
  logic              fin;
  logic              sym_hi;
  logic [CODE_W-1:0] code_sr;
  logic [LEN_W-1:0]  len_left;

  // Pending bits, newest in bit 0; bits above count are always zero.
  logic [BYTE_W-2:0]  acc;
  logic [COUNT_W-1:0] count;

  logic [BYTE_W-1:0] held_byte;
  logic              held_valid;

  logic [SYM_W-1:0]  sym;
  logic [LEN_W-1:0]  len_raw;
  logic [LEN_W-1:0]  len_lookup;
  logic [CODE_W-1:0] code_lookup;
  logic              can_push;
  logic              out_push;
  logic [BYTE_W-1:0] flush_byte;
  logic [LEN_W-1:0]  flush_shamt;
  logic              end_run;
  logic              end_stream;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign can_push  = !out_valid || out_ready;

  // A word is loaded into the output register when an older held byte is
  // displaced by a new one, or when the end of an input word sends one out.
  assign out_push  = can_push &&
                     (((state == ST_SHIFT) && (len_left != '0) &&
                       (count == COUNT_W'(BYTE_W - 1)) && held_valid) ||
                      ((state == ST_END) && (held_valid || fin)));

  always_comb begin
    sym         = sym_hi ? data[BYTE_W-1:SYM_W] : data[SYM_W-1:0];
    len_raw     = code_lengths[{sym, 2'b00} +: LEN_W];
    len_lookup  = (len_raw > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : len_raw;
    code_lookup = codes[sym[3:2]][{sym[1:0], 4'b0000} +: CODE_W];
    flush_shamt = LEN_W'(BYTE_W) - {1'b0, count};
    flush_byte  = BYTE_W'({1'b0, acc} << flush_shamt);
    // With a flush still due, the held byte is not the last of the run.
    end_run     = !(fin && (count != '0));
    end_stream  = fin && (count == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      held_valid   <= 1'b0;
      acc          <= '0;
      count        <= '0;
      codes[0]     <= '0;
      codes[1]     <= '0;
      codes[2]     <= '0;
      codes[3]     <= '0;
      code_lengths <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_CODES_SYM0:   codes[0]     <= cfg_data;
          REG_CODES_SYM4:   codes[1]     <= cfg_data;
          REG_CODES_SYM8:   codes[2]     <= cfg_data;
          REG_CODES_SYM12:  codes[3]     <= cfg_data;
          REG_CODE_LENGTHS: code_lengths <= cfg_data;
          default: ;
        endcase
      end

      if (out_push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            data   <= in_word.data_byte;
            fin    <= in_word.final_byte;
            sym_hi <= 1'b0;
            state  <= ST_LOAD;
          end
        end

        ST_LOAD: begin
          code_sr  <= code_lookup;
          len_left <= len_lookup;
          state    <= ST_SHIFT;
        end

        ST_SHIFT: begin
          if (len_left != '0) begin
            if (count == COUNT_W'(BYTE_W - 1)) begin
              // The eighth bit completes a byte; the older held byte goes out.
              if (!held_valid || can_push) begin
                if (held_valid) begin
                  out_word  <= '{packed_byte: held_byte, run_end: 1'b0,
                                 stream_end: 1'b0};
                end
                held_byte  <= {acc, code_sr[0]};
                held_valid <= 1'b1;
                acc        <= '0;
                count      <= '0;
                code_sr    <= code_sr >> 1;
                len_left   <= len_left - 1'b1;
              end
            end else begin
              acc      <= {acc[BYTE_W-3:0], code_sr[0]};
              count    <= count + 1'b1;
              code_sr  <= code_sr >> 1;
              len_left <= len_left - 1'b1;
            end
          end else if (!sym_hi) begin
            sym_hi <= 1'b1;
            state  <= ST_LOAD;
          end else begin
            state <= ST_END;
          end
        end

        ST_END: begin
          if (held_valid) begin
            if (can_push) begin
              out_word   <= '{packed_byte: held_byte, run_end: end_run,
                              stream_end: end_stream};
              held_valid <= 1'b0;
              if (end_run) begin
                state <= ST_IDLE;
                if (fin) begin
                  acc   <= '0;
                  count <= '0;
                end
              end
            end
          end else if (fin) begin
            if (can_push) begin
              out_word  <= '{packed_byte: (count != '0) ? flush_byte : '0,
                             run_end: 1'b1, stream_end: 1'b1};
              acc       <= '0;
              count     <= '0;
              state     <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_stream_end_ends_run,
    out_valid |-> (!out_word.stream_end || out_word.run_end),
    "stream_end without run_end")
  `ASSERT_CLK(a_stream_end_clears_pending,
    (out_valid && out_word.stream_end && !$stable(out_word)) |-> (count == '0),
    "pending bits left after end of stream")
  `ASSERT_CLK(a_held_only_when_busy,
    held_valid |-> (state != ST_IDLE),
    "held byte left behind at idle")
  `ASSERT_CLK(a_acc_above_count_zero,
    ((acc >> count) == '0),
    "stale bits above the pending count")

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the nibble Huffman encoder: directed tables, random
// streams, output stalls and back-pressure, each word checked against a predictor.
// Depends on nhe_pkg and nibble_huffman_encoder.
module testbench;
  import nhe_pkg::*;

  localparam int CODE_LEN_CAP  = 15;
  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 46;
  localparam int MAX_PRINTS    = 20;

  typedef enum int {TBL_SHORT, TBL_ANY, TBL_LONG, TBL_ONES, TBL_SILENT} table_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_word;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow of the code tables and of the bits still waiting to form a byte.
  logic [CFG_DATA_W-1:0] table_regs [NUM_CFG_REGS];
  logic [CFG_DATA_W-1:0] cfg_next   [NUM_CFG_REGS];
  logic [6:0]            pend_bits;
  int                    pend_count;

  out_word_t expected_words[$];

  int errors         = 0;
  int bytes_sent     = 0;
  int streams_closed = 0;
  int words_checked  = 0;
  int settings_used  = 0;
  int idle_cycles    = 0;
  int hold_len       = 0;
  bit in_gaps_on     = 1'b1;
  bit out_stalls_on  = 1'b1;

  nibble_huffman_encoder #(
    .MAX_CODE_LEN(CODE_LEN_CAP)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Encodes both nibbles of one source byte and queues the packed words it yields.
  task automatic encode_and_queue(input in_word_t w);
    logic [7:0]  acc;
    logic [15:0] code;
    logic [7:0]  bytes [5];
    out_word_t   word;
    int          n, len, s, cnt;
    acc = {1'b0, pend_bits};
    n = pend_count;
    cnt = 0;
    for (int h = 0; h < 2; h++) begin
      s = int'((h == 0) ? w.data_byte[3:0] : w.data_byte[7:4]);
      len = int'(table_regs[REG_CODE_LENGTHS][s*4 +: 4]);
      if (len > CODE_LEN_CAP) len = CODE_LEN_CAP;
      code = table_regs[s/4][(s%4)*16 +: 16];
      for (int i = 0; i < len; i++) begin
        acc = {acc[6:0], code[i]};
        n++;
        if (n == 8) begin
          bytes[cnt] = acc;
          cnt++;
          acc = '0;
          n = 0;
        end
      end
    end
    if (w.final_byte) begin
      if (n > 0) begin
        bytes[cnt] = acc << (8 - n);
        cnt++;
      end else if (cnt == 0) begin
        bytes[cnt] = '0;
        cnt++;
      end
      acc = '0;
      n = 0;
    end
    for (int k = 0; k < cnt; k++) begin
      word.packed_byte = bytes[k];
      word.run_end     = (k == cnt - 1);
      word.stream_end  = w.final_byte && (k == cnt - 1);
      expected_words.push_back(word);
    end
    pend_bits = acc[6:0];
    pend_count = n;
  endtask

  // Leaves in_valid high after acceptance so that a back-to-back word needs no toggle.
  task automatic send_byte(input logic [7:0] data, input logic fin);
    int       gap;
    in_word_t w;
    gap = (in_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    w.data_byte = data;
    w.final_byte = fin;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    encode_and_queue(w);
    bytes_sent++;
    if (fin) streams_closed++;
  endtask

  task automatic send_stream(input int len);
    for (int k = 0; k < len; k++) send_byte(8'($urandom), k == len - 1);
  endtask

  // The sender stops until every queued word is back and the encoder has gone quiet.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tables();
    for (int r = REG_CODES_SYM0; r <= REG_CODE_LENGTHS; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data <= cfg_next[r];
      do @(posedge clk); while (!cfg_ready);
      table_regs[r] = cfg_next[r];
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic load_table(input table_mode_t mode);
    for (int r = REG_CODES_SYM0; r <= REG_CODE_LENGTHS; r++) begin
      case (mode)
        TBL_ONES:   cfg_next[r] = '1;
        TBL_SILENT: cfg_next[r] = (r == REG_CODE_LENGTHS) ? '0 : '1;
        default:    cfg_next[r] = {$urandom, $urandom};
      endcase
    end
    for (int s = 0; s < 16; s++) begin
      case (mode)
        TBL_SHORT: cfg_next[REG_CODE_LENGTHS][s*4 +: 4] =
                     4'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
        TBL_LONG:  cfg_next[REG_CODE_LENGTHS][s*4 +: 4] = 4'($urandom_range(10, 15));
        default: ;
      endcase
    end
    write_tables();
  endtask

  task automatic test_empty_tables();
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_for_results();
  endtask

  task automatic test_byte_aligned_codes();
    for (int r = REG_CODES_SYM0; r < REG_CODE_LENGTHS; r++) cfg_next[r] = {$urandom, $urandom};
    cfg_next[REG_CODE_LENGTHS] = 64'h8888_8888_8888_8888;
    write_tables();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h3C, 1'b1);
    wait_for_results();
  endtask

  task automatic test_longest_codes();
    load_table(TBL_ONES);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_for_results();
    // Only the bit just above the fifteenth is set, so every emitted bit must be zero.
    for (int r = REG_CODES_SYM0; r < REG_CODE_LENGTHS; r++) cfg_next[r] = 64'h8000_8000_8000_8000;
    write_tables();
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    wait_for_results();
  endtask

  task automatic test_mixed_lengths();
    for (int r = REG_CODES_SYM0; r < REG_CODE_LENGTHS; r++) cfg_next[r] = {$urandom, $urandom};
    cfg_next[REG_CODE_LENGTHS] = 64'hFEDC_BA98_7654_3210;
    write_tables();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hF1, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h0F, 1'b1);
    send_byte(8'hF0, 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_streams();
    table_mode_t mode;
    int          start;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       mode = TBL_ONES;
        1:       mode = TBL_SILENT;
        2, 7:    mode = TBL_ANY;
        5:       mode = TBL_LONG;
        default: mode = TBL_SHORT;
      endcase
      load_table(mode);
      in_gaps_on = (phase % 3 != 2);
      out_stalls_on = (phase % 4 != 3);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) send_byte(8'($urandom), $urandom_range(0, 5) == 0);
        else send_stream($urandom_range(1, 10));
      end
      wait_for_results();
    end
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // The receiver stops for a long stretch while words keep coming, so the input stalls.
  task automatic test_output_backpressure();
    load_table(TBL_LONG);
    in_gaps_on = 1'b0;
    hold_len = 300;
    for (int k = 0; k < 3; k++) send_stream(8);
    wait_for_results();
    in_gaps_on = 1'b1;
  endtask

  initial begin : receiver
    int low_left;
    low_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        hold_len = hold_len - 1;
      end else if (low_left > 0) begin
        out_ready <= 1'b0;
        low_left--;
      end else if (!out_stalls_on || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        low_left = pick_gap() - 1;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= MAX_PRINTS)
          $display("%0t: word %h/%b/%b with none expected", $time,
                   out_word.packed_byte, out_word.run_end, out_word.stream_end);
      end else begin
        want = expected_words.pop_front();
        if (out_word !== want) begin
          errors++;
          if (errors <= MAX_PRINTS)
            $display("%0t: packed_byte/run_end/stream_end expected %h/%b/%b, got %h/%b/%b",
                     $time, want.packed_byte, want.run_end, want.stream_end,
                     out_word.packed_byte, out_word.run_end, out_word.stream_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("nibble_huffman_encoder: mismatch");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    for (int r = REG_CODES_SYM0; r <= REG_CODE_LENGTHS; r++) table_regs[r] = '0;
    pend_bits = '0;
    pend_count = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_empty_tables();
    test_byte_aligned_codes();
    test_longest_codes();
    test_mixed_lengths();
    test_random_streams();
    test_output_backpressure();
    wait_for_results();

    $display("Sent %0d bytes in %0d closed streams over %0d table settings; checked %0d words.",
             bytes_sent, streams_closed, settings_used, words_checked);
    if (errors == 0 && expected_words.size() == 0)
      $display("nibble_huffman_encoder: match");
    else
      $display("nibble_huffman_encoder: mismatch");
    $finish;
  end

endmodule
